// File: rtl/arpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache package
// Shared types, codes and constants for the ARP cache table.
// ----------------------------------------------------------------------------
package arpc_pkg;

    // field widths
    localparam int OP_W            = 2;
    localparam int IP_W            = 32;
    localparam int MAC_W           = 48;
    localparam int STAMP_W         = 16;
    localparam int MAX_AGE_W       = 15;
    localparam int ACTION_W        = 2;
    localparam int ENTRY_INDEX_W   = 4;
    localparam int EXPIRED_W       = 5;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam logic [MAX_AGE_W-1:0] MAX_AGE_RESET = 15'd120;

    // op codes on the input
    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_LEARN  = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    // learn result codes
    localparam logic [ACTION_W-1:0] ACT_UPDATED  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERTED = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REPLACED = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NONE     = 2'd3;

    // what the latched item asks for
    typedef enum logic [1:0] {
        K_NONE,
        K_TICK,
        K_LEARN,
        K_LOOKUP
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT,
        S_RESP
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;       // latch item, reset scan state
        logic scan_step;  // read next entry
        logic commit;     // write learn, build result
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;  // entry being read is the last one
    } t_dp_sts;

endpackage

// File: rtl/arpc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/arpc_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache datapath
// Entry store, valid bits, age clock, scan evaluation and result registers.
// ----------------------------------------------------------------------------
module arpc_dpath import arpc_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_sts                  o_sts,
    input  logic                     i_cfg_we,
    input  logic [MAX_AGE_W-1:0]     i_cfg_max_age,
    input  logic [OP_W-1:0]          i_op,
    input  logic [IP_W-1:0]          i_ip_address,
    input  logic [MAC_W-1:0]         i_mac_address,
    output logic                     o_hit,
    output logic [MAC_W-1:0]         o_found_mac,
    output logic [ACTION_W-1:0]      o_learn_action,
    output logic [ENTRY_INDEX_W-1:0] o_entry_index,
    output logic [EXPIRED_W-1:0]     o_expired_count
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int ENT_W = IP_W + MAC_W + STAMP_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // item and config
    t_kind                  r_kind;
    t_kind                  n_kind;
    logic [IP_W-1:0]        r_ip;
    logic [MAC_W-1:0]       r_mac;
    logic [MAX_AGE_W-1:0]   r_max_age;
    logic [STAMP_W-1:0]     r_age_clock;
    logic [TABLE_ENTRIES-1:0] r_valid;

    // scan
    logic [IDX_W-1:0]       r_scan_idx;
    logic                   r_eval_vld;
    logic [IDX_W-1:0]       r_eval_idx;
    logic                   r_found;
    logic [IDX_W-1:0]       r_match_idx;
    logic [MAC_W-1:0]       r_match_mac;
    logic                   r_free_found;
    logic [IDX_W-1:0]       r_free_idx;
    logic [STAMP_W-1:0]     r_best_age;
    logic [IDX_W-1:0]       r_best_idx;
    logic [CNT_W-1:0]       r_exp_cnt;

    // results
    logic                     r_res_hit;
    logic [MAC_W-1:0]         r_res_mac;
    logic [ACTION_W-1:0]      r_res_action;
    logic [ENTRY_INDEX_W-1:0] r_res_idx;
    logic [EXPIRED_W-1:0]     r_res_exp;

    // RAM side
    logic             w_ram_we;
    logic [ENT_W-1:0] w_rdata;

    // evaluation of the entry read last cycle
    logic               w_e_valid;
    logic [IP_W-1:0]    w_e_ip;
    logic [MAC_W-1:0]   w_e_mac;
    logic [STAMP_W-1:0] w_e_stamp;
    logic [STAMP_W-1:0] w_e_age;
    logic               w_e_match;
    logic               w_e_expire;

    // commit
    logic [IDX_W-1:0]                 n_slot;
    logic [IDX_W-1:0]                 n_res_idx;
    logic [IDX_W+ENTRY_INDEX_W-1:0]   w_res_idx_ext;
    logic [CNT_W+EXPIRED_W-1:0]       w_exp_ext;
    logic [ACTION_W-1:0]              n_action;

    always_comb begin
        case (i_op)
            OP_TICK:   n_kind = K_TICK;
            OP_LEARN:  n_kind = (i_ip_address != '0) ? K_LEARN : K_NONE;
            OP_LOOKUP: n_kind = (i_ip_address != '0) ? K_LOOKUP : K_NONE;
            default:   n_kind = K_NONE;
        endcase
    end

    assign o_sts.scan_last = (r_scan_idx == LAST_IDX);

    assign w_e_valid  = r_valid[r_eval_idx];
    assign w_e_ip     = w_rdata[ENT_W-1 -: IP_W];
    assign w_e_mac    = w_rdata[STAMP_W +: MAC_W];
    assign w_e_stamp  = w_rdata[STAMP_W-1:0];
    assign w_e_age    = r_age_clock - w_e_stamp;
    assign w_e_match  = w_e_valid && (w_e_ip == r_ip);
    assign w_e_expire = w_e_valid && (w_e_age >= {1'b0, r_max_age});

    // match first, then first free, then oldest
    always_comb begin
        if (r_found) begin
            n_slot   = r_match_idx;
            n_action = ACT_UPDATED;
        end else if (r_free_found) begin
            n_slot   = r_free_idx;
            n_action = ACT_INSERTED;
        end else begin
            n_slot   = r_best_idx;
            n_action = ACT_REPLACED;
        end
    end

    always_comb begin
        case (r_kind)
            K_LEARN:  n_res_idx = n_slot;
            K_LOOKUP: n_res_idx = r_found ? r_match_idx : '0;
            default:  n_res_idx = '0;
        endcase
    end

    assign w_res_idx_ext = {{ENTRY_INDEX_W{1'b0}}, n_res_idx};
    assign w_exp_ext     = {{EXPIRED_W{1'b0}}, r_exp_cnt};
    assign w_ram_we      = i_cmd.commit && (r_kind == K_LEARN);

    arpc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (n_slot),
        .i_wdata ({r_ip, r_mac, r_age_clock}),
        .i_re    (i_cmd.scan_step),
        .i_raddr (r_scan_idx),
        .o_rdata (w_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_age   <= MAX_AGE_RESET;
            r_age_clock <= '0;
            r_valid     <= '0;
            r_scan_idx  <= '0;
            r_eval_vld  <= 1'b0;
            r_kind      <= K_NONE;
            r_exp_cnt   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_max_age <= i_cfg_max_age;
            end
            r_eval_vld <= i_cmd.scan_step;
            if (i_cmd.load) begin
                r_kind     <= n_kind;
                r_scan_idx <= '0;
                r_exp_cnt  <= '0;
                if (n_kind == K_TICK) begin
                    r_age_clock <= r_age_clock + STAMP_W'(1);
                end
            end else if (i_cmd.scan_step && !o_sts.scan_last) begin
                r_scan_idx <= r_scan_idx + IDX_W'(1);
            end
            if (r_eval_vld && (r_kind == K_TICK) && w_e_expire) begin
                r_valid[r_eval_idx] <= 1'b0;
                r_exp_cnt           <= r_exp_cnt + CNT_W'(1);
            end
            if (w_ram_we) begin
                r_valid[n_slot] <= 1'b1;
            end
        end
    end

    // item payload and scan trackers
    always_ff @(posedge i_clk) begin
        r_eval_idx <= r_scan_idx;
        if (i_cmd.load) begin
            r_ip         <= i_ip_address;
            r_mac        <= i_mac_address;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_best_age   <= '0;
            r_best_idx   <= '0;
        end else if (r_eval_vld) begin
            if (w_e_match && !r_found) begin
                r_found     <= 1'b1;
                r_match_idx <= r_eval_idx;
                r_match_mac <= w_e_mac;
            end
            if (!w_e_valid && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_eval_idx;
            end
            // strictly greater keeps the earliest of equal ages
            if (w_e_valid && (w_e_age > r_best_age)) begin
                r_best_age <= w_e_age;
                r_best_idx <= r_eval_idx;
            end
        end
        if (i_cmd.commit) begin
            r_res_hit    <= (r_kind == K_LOOKUP) && r_found;
            r_res_mac    <= ((r_kind == K_LOOKUP) && r_found) ? r_match_mac : '0;
            r_res_action <= (r_kind == K_LEARN) ? n_action : ACT_NONE;
            r_res_idx    <= w_res_idx_ext[ENTRY_INDEX_W-1:0];
            r_res_exp    <= (r_kind == K_TICK) ? w_exp_ext[EXPIRED_W-1:0] : '0;
        end
    end

    assign o_hit           = r_res_hit;
    assign o_found_mac     = r_res_mac;
    assign o_learn_action  = r_res_action;
    assign o_entry_index   = r_res_idx;
    assign o_expired_count = r_res_exp;

    // commit only once the last read has been evaluated
    a_commit_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> !r_eval_vld)
        else $error("commit while scan evaluation pending");

    a_scan_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_scan_idx == '0) && (r_exp_cnt == '0))
        else $error("scan state not cleared on load");

    a_exp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_exp_cnt <= CNT_W'(TABLE_ENTRIES))
        else $error("expired count beyond table size");

endmodule

// File: rtl/arpc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache controller
// Sequences accept, table scan, commit and result strobe.
// ----------------------------------------------------------------------------
module arpc_ctrl import arpc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_busy,
    output logic    o_result_valid
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        case (r_state)
            S_IDLE:   n_state = i_start ? S_SCAN : S_IDLE;
            S_SCAN:   n_state = i_sts.scan_last ? S_DRAIN : S_SCAN;
            S_DRAIN:  n_state = S_COMMIT;
            S_COMMIT: n_state = S_RESP;
            S_RESP:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_busy         = 1'b1;
        o_result_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            S_SCAN:   o_cmd.scan_step = 1'b1;
            S_DRAIN:  o_cmd = '0;
            S_COMMIT: o_cmd.commit = 1'b1;
            S_RESP:   o_result_valid = 1'b1;
            default:  o_busy = 1'b1;
        endcase
    end

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (r_state == S_SCAN))
        else $error("accepted item did not start a scan");

    a_result_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(o_cmd.commit))
        else $error("result strobe without a commit");

    a_result_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_busy)
        else $error("still busy after result");

endmodule

// File: rtl/arp_cache_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache table
// IPv4-to-MAC cache with aging: tick, learn and lookup on one command port.
// ----------------------------------------------------------------------------
// Usage: present an item on i_op / i_ip_address / i_mac_address with start
// high; it is taken on a clock edge where busy is low. Every item, whatever
// its op, runs through the same steps: the idle cycle with busy low that
// ends in the accept, a walk of the entry RAM through its single registered
// read port, one entry per cycle, an evaluation of the last read, a write
// back of a learn with the build of the result, then the result itself. The
// result shows for exactly one cycle with o_result_valid high; the receiver
// cannot hold it off, so it must take it then. busy drops in the cycle after
// the strobe. The outputs keep the last result until the next one.
// max_age is written through i_cfg_we / i_cfg_max_age; the user must write
// it only while idle, which the block itself does not enforce.
// No clearing pass is needed after reset: free entries are tracked by
// flip-flop valid bits cleared at reset.
// ----------------------------------------------------------------------------
// Behaviour notes:
//  - tick: age clock advances first, then every used entry whose age
//    (clock minus stamp, mod 2^16) has reached max_age is freed.
//  - learn: refresh a match, else first free entry, else the entry with
//    strictly greatest age (entry 0 when all ages are zero).
//  - learn or lookup of IP zero, and the unused op code, change nothing.
//  - entry_index and expired_count carry only their low bits.
// ----------------------------------------------------------------------------
module arp_cache_table import arpc_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // command handshake
    input  logic                     start,
    output logic                     busy,
    // configuration
    input  logic                     i_cfg_we,
    input  logic [MAX_AGE_W-1:0]     i_cfg_max_age,
    // item
    input  logic [OP_W-1:0]          i_op,
    input  logic [IP_W-1:0]          i_ip_address,
    input  logic [MAC_W-1:0]         i_mac_address,
    // result
    output logic                     o_result_valid,
    output logic                     o_hit,
    output logic [MAC_W-1:0]         o_found_mac,
    output logic [ACTION_W-1:0]      o_learn_action,
    output logic [ENTRY_INDEX_W-1:0] o_entry_index,
    output logic [EXPIRED_W-1:0]     o_expired_count
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // sequencer: idle -> scan -> drain -> commit -> result
    arpc_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_sts          (w_sts),
        .o_cmd          (w_cmd),
        .o_busy         (busy),
        .o_result_valid (o_result_valid)
    );

    // entry store, valid bits, age clock and per-scan trackers
    arpc_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_max_age   (i_cfg_max_age),
        .i_op            (i_op),
        .i_ip_address    (i_ip_address),
        .i_mac_address   (i_mac_address),
        .o_hit           (o_hit),
        .o_found_mac     (o_found_mac),
        .o_learn_action  (o_learn_action),
        .o_entry_index   (o_entry_index),
        .o_expired_count (o_expired_count)
    );

endmodule
